>>> rtl/rrss_pkg.sv
// Shared constants, types and ring index helper for the round-robin slice scheduler.
package rrss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int ID_W        = 16;
  localparam int DUR_W       = 16;
  localparam int ENTRY_W     = ID_W + DUR_W;
  localparam int QUANTUM_W   = 8;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 3;

  localparam int IN_DATA_W   = DUR_W;
  localparam int OUT_DATA_W  = ((ID_W + DUR_W + CNT_W + 7) / 8) * 8;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = QUANTUM_W'(2);
  localparam logic [ID_W-1:0]      ID_RST      = ID_W'(1);

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SLICE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KILL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BONUS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ROTATED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_KILLED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BONUS    = 3'd7;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] data;
  } ring_wr_t;

  // base < depth and off <= depth, so one conditional subtract wraps the sum
  function automatic logic [IDX_W-1:0] slot_after(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      wrapped = sum - SUM_W'(QUEUE_DEPTH);
    end else begin
      wrapped = sum;
    end
    return wrapped[IDX_W-1:0];
  endfunction

endpackage

>>> rtl/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler over a ring of queued tasks.
//
//  Channel  Direction  Transfers
//  in_      slave      one command transaction (kind in tuser, duration in tdata)
//  out_     master     one result transaction (status in tuser)
//  cfg_     write      slice quantum register
//
//  One command per cycle while in_tready is high; the result appears in the cycle after acceptance.
//  Head read, charge subtract and tail write all sit in the single accept cycle.
//  in_tready drops only while a result is held by out_tready low.
//  Kinds 5 to 7 are accepted and produce no result.
//  Synchronous active-low reset; the ring contents are not cleared.
module round_robin_slice_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rrss_pkg::IN_DATA_W-1:0]     in_tdata,   // duration[15:0]
  input  logic [rrss_pkg::KIND_W-1:0]        in_tuser,   // kind[2:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rrss_pkg::OUT_DATA_W-1:0]    out_tdata,  // task_id, remaining, queue_count, pad
  output logic [rrss_pkg::STATUS_W-1:0]      out_tuser,  // status[2:0]
  input  logic                               cfg_wen,
  input  logic [rrss_pkg::QUANTUM_W-1:0]     cfg_wdata
);

  logic [rrss_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic [rrss_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rrss_pkg::ID_W-1:0]      next_id_r, next_id_nxt;
  logic                           bonus_r, bonus_nxt;
  logic [rrss_pkg::QUANTUM_W-1:0] quantum_r;
  logic                           out_valid_r;
  logic [rrss_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [rrss_pkg::ID_W-1:0]      tid_r, tid_nxt;
  logic [rrss_pkg::DUR_W-1:0]     rem_r, rem_nxt;
  logic [rrss_pkg::CNT_W-1:0]     qcnt_r;

  rrss_pkg::ring_wr_t             ring_wr;
  logic [rrss_pkg::ENTRY_W-1:0]   head_entry;
  logic [rrss_pkg::IDX_W-1:0]     tail_idx;
  logic [rrss_pkg::IDX_W-1:0]     head_inc;
  logic [rrss_pkg::ID_W-1:0]      head_id;
  logic [rrss_pkg::DUR_W-1:0]     head_rem;
  logic [rrss_pkg::QUANTUM_W:0]   charge;
  logic [rrss_pkg::DUR_W-1:0]     charge_ext;
  logic                           in_acc;
  logic                           res_valid;

  rrss_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_addr (head_r),
    .rd_data (head_entry)
  );

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;

  assign tail_idx   = rrss_pkg::slot_after(head_r, cnt_r);
  assign head_inc   = rrss_pkg::slot_after(head_r, rrss_pkg::CNT_W'(1));
  assign head_id    = head_entry[rrss_pkg::ENTRY_W-1:rrss_pkg::DUR_W];
  assign head_rem   = head_entry[rrss_pkg::DUR_W-1:0];
  assign charge     = {1'b0, quantum_r} + (rrss_pkg::QUANTUM_W + 1)'(bonus_r);
  assign charge_ext = rrss_pkg::DUR_W'(charge);

  always_comb begin
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    next_id_nxt  = next_id_r;
    bonus_nxt    = bonus_r;
    ring_wr      = '0;
    res_valid    = 1'b1;
    status_nxt   = rrss_pkg::ST_EMPTY;
    tid_nxt      = '0;
    rem_nxt      = '0;
    unique case (in_tuser)
      rrss_pkg::KIND_ADD: begin
        if (cnt_r >= rrss_pkg::CNT_W'(rrss_pkg::QUEUE_DEPTH)) begin
          status_nxt = rrss_pkg::ST_FULL;
        end else begin
          ring_wr.en   = 1'b1;
          ring_wr.addr = tail_idx;
          ring_wr.data = {next_id_r, in_tdata[rrss_pkg::DUR_W-1:0]};
          cnt_nxt      = cnt_r + rrss_pkg::CNT_W'(1);
          next_id_nxt  = next_id_r + rrss_pkg::ID_W'(1);
          status_nxt   = rrss_pkg::ST_ADDED;
          tid_nxt      = next_id_r;
          rem_nxt      = in_tdata[rrss_pkg::DUR_W-1:0];
        end
      end
      rrss_pkg::KIND_SLICE: begin
        if (cnt_r != '0) begin
          bonus_nxt = 1'b0;
          head_nxt  = head_inc;
          tid_nxt   = head_id;
          if (head_rem > charge_ext) begin
            ring_wr.en   = 1'b1;
            ring_wr.addr = tail_idx;
            ring_wr.data = {head_id, head_rem - charge_ext};
            status_nxt   = rrss_pkg::ST_ROTATED;
            rem_nxt      = head_rem - charge_ext;
          end else begin
            cnt_nxt    = cnt_r - rrss_pkg::CNT_W'(1);
            status_nxt = rrss_pkg::ST_FINISHED;
          end
        end
      end
      rrss_pkg::KIND_KILL: begin
        if (cnt_r != '0) begin
          head_nxt   = head_inc;
          cnt_nxt    = cnt_r - rrss_pkg::CNT_W'(1);
          status_nxt = rrss_pkg::ST_KILLED;
          tid_nxt    = head_id;
          rem_nxt    = head_rem;
        end
      end
      rrss_pkg::KIND_BONUS: begin
        bonus_nxt  = 1'b1;
        status_nxt = rrss_pkg::ST_BONUS;
      end
      rrss_pkg::KIND_CLEAR: begin
        head_nxt   = '0;
        cnt_nxt    = '0;
        status_nxt = rrss_pkg::ST_CLEARED;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (!in_acc) begin
      ring_wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      next_id_r   <= rrss_pkg::ID_RST;
      bonus_r     <= 1'b0;
      quantum_r   <= rrss_pkg::QUANTUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        quantum_r <= cfg_wdata;
      end
      if (in_acc) begin
        head_r    <= head_nxt;
        cnt_r     <= cnt_nxt;
        next_id_r <= next_id_nxt;
        bonus_r   <= bonus_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_acc && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      tid_r    <= tid_nxt;
      rem_r    <= rem_nxt;
      qcnt_r   <= cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = rrss_pkg::OUT_DATA_W'({qcnt_r, rem_r, tid_r});

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rrss_pkg::CNT_W'(rrss_pkg::QUEUE_DEPTH))
    else $error("task count beyond queue depth");

  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == rrss_pkg::ST_FINISHED |-> rem_r == '0)
    else $error("finished task reported with remaining duration");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == rrss_pkg::KIND_CLEAR |=> cnt_r == '0 && head_r == '0)
    else $error("clear left tasks queued");

  a_empty_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == rrss_pkg::ST_EMPTY |-> tid_r == '0 && qcnt_r == '0)
    else $error("empty result carries a task");

endmodule

>>> rtl/rrss_ring.sv
// Task ring storage: one write port at the tail, one read port at the head.
module rrss_ring (
  input  logic                          clk,
  input  rrss_pkg::ring_wr_t            wr,
  input  logic [rrss_pkg::IDX_W-1:0]    rd_addr,
  output logic [rrss_pkg::ENTRY_W-1:0]  rd_data
);

  logic [rrss_pkg::ENTRY_W-1:0] ring_r [rrss_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ring_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = ring_r[rd_addr];

endmodule
